// ===== rtl/nrsi_pkg.sv =====
// Shared types, constants and datapath functions of the nearest-neighbor
// resize source index generator. No dependencies; used by every module in rtl/.
package nrsi_pkg;

    localparam int IDX_W  = 12;   // row, column and plane indexes
    localparam int DIM_W  = 13;   // dimension registers, 1..4096
    localparam int ADDR_W = 36;   // linear element addresses
    localparam int NUM_W  = 26;   // (2o+1)*in fits here
    localparam int DIV_W  = 14;   // divisor, up to 2*out
    localparam int Q_W    = 12;   // quotient bits resolved by the divider
    localparam int CIDX_W = 3;    // register index on the config port

    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_IN_H  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_IN_W  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_OUT_H = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_OUT_W = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MODE  = 3'd4;

    localparam logic MODE_ASYM = 1'b0;
    localparam logic MODE_HALF = 1'b1;

    // pipeline stage positions
    localparam int ST_INIT = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_PICK = ST_DIV0 + Q_W;
    localparam int ST_SCALE = ST_PICK + 1;
    localparam int ST_OUT = ST_SCALE + 1;
    localparam int NUM_STG = ST_OUT + 1;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 96;

    typedef struct packed {
        logic [DIM_W-1:0] in_h;
        logic [DIM_W-1:0] in_w;
        logic [DIM_W-1:0] out_h;
        logic [DIM_W-1:0] out_w;
        logic             mode;
    } t_cfg;

    // one restoring-division lane
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   q;
        logic             zero;   // half-pixel coordinate below zero
        logic             sat;    // quotient at or above 2^Q_W
    } t_lane;

    typedef struct packed {
        t_lane             lr;
        t_lane             lc;
        logic [NUM_W-1:0]  nr;
        logic [NUM_W-1:0]  nc;
        logic [IDX_W-1:0]  orow;
        logic [IDX_W-1:0]  ocol;
        logic [IDX_W-1:0]  srow;
        logic [IDX_W-1:0]  scol;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
    } t_stg;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end
        return r;
    endfunction

    function automatic logic [DIV_W-1:0] div_of(input logic [DIM_W-1:0] nout,
                                                input logic mode);
        return (mode == MODE_HALF) ? {nout, 1'b0} : {1'b0, nout};
    endfunction

    // scaled output coordinate: o*in or (2o+1)*in
    function automatic logic [NUM_W-1:0] scale_num(input logic [IDX_W-1:0] o,
                                                   input logic [DIM_W-1:0] nin,
                                                   input logic mode);
        logic [DIM_W-1:0] m;
        m = (mode == MODE_HALF) ? {o, 1'b1} : {1'b0, o};
        return NUM_W'(m) * NUM_W'(nin);
    endfunction

    function automatic t_lane lane_init(input logic [NUM_W-1:0] num,
                                        input logic [DIM_W-1:0] nout,
                                        input logic mode);
        t_lane            l;
        logic [DIV_W-1:0] d;
        logic [NUM_W-1:0] n;
        logic             neg;
        d   = div_of(nout, mode);
        neg = (mode == MODE_HALF) && (num < NUM_W'(nout));
        n   = (mode == MODE_HALF) ? (num - NUM_W'(nout)) : num;
        l.zero = neg;
        l.sat  = !neg && (n[NUM_W-1:Q_W] >= d);
        l.rem  = n[NUM_W-1:Q_W];
        l.low  = n[Q_W-1:0];
        l.q    = '0;
        return l;
    endfunction

    // resolve one quotient bit
    function automatic t_lane div_step(input t_lane l, input logic [DIV_W-1:0] d);
        t_lane          r;
        logic [DIV_W:0] t;
        r = l;
        t = {l.rem, l.low[Q_W-1]};
        if (t >= {1'b0, d}) begin
            r.rem = DIV_W'(t - {1'b0, d});
            r.q   = {l.q[Q_W-2:0], 1'b1};
        end else begin
            r.rem = t[DIV_W-1:0];
            r.q   = {l.q[Q_W-2:0], 1'b0};
        end
        r.low = {l.low[Q_W-2:0], 1'b0};
        return r;
    endfunction

    // floor result clamped to [0, in-1]
    function automatic logic [IDX_W-1:0] pick_idx(input t_lane l,
                                                  input logic [DIM_W-1:0] nin);
        logic [IDX_W-1:0] lim;
        logic [IDX_W-1:0] r;
        lim = IDX_W'(nin - DIM_W'(1));
        if (l.zero) begin
            r = '0;
        end else if (l.sat || (l.q > lim)) begin
            r = lim;
        end else begin
            r = l.q;
        end
        return r;
    endfunction

endpackage

// ===== rtl/nrsi_cfg.sv =====
// Configuration registers of the resize index generator: takes register writes
// and holds the effective (clamped) dimensions and the coordinate mode. Uses nrsi_pkg.
module nrsi_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nrsi_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [nrsi_pkg::DIM_W-1:0]    i_cfg_data,
    output nrsi_pkg::t_cfg                o_cfg
);

    nrsi_pkg::t_cfg r_cfg;
    nrsi_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                nrsi_pkg::CFG_IN_H:  n_cfg.in_h  = nrsi_pkg::eff_dim(i_cfg_data);
                nrsi_pkg::CFG_IN_W:  n_cfg.in_w  = nrsi_pkg::eff_dim(i_cfg_data);
                nrsi_pkg::CFG_OUT_H: n_cfg.out_h = nrsi_pkg::eff_dim(i_cfg_data);
                nrsi_pkg::CFG_OUT_W: n_cfg.out_w = nrsi_pkg::eff_dim(i_cfg_data);
                nrsi_pkg::CFG_MODE:  n_cfg.mode  = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_h  <= nrsi_pkg::DIM_W'(1);
            r_cfg.in_w  <= nrsi_pkg::DIM_W'(1);
            r_cfg.out_h <= nrsi_pkg::DIM_W'(1);
            r_cfg.out_w <= nrsi_pkg::DIM_W'(1);
            r_cfg.mode  <= nrsi_pkg::MODE_ASYM;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/nearest_resize_source_index.sv =====
// Top level of the nearest-neighbor resize source index generator: stream in,
// stream out, with a 17-stage datapath. Uses nrsi_pkg and nrsi_cfg.
//
// Takes one output coordinate (plane, row, column) per transfer and returns the
// nearest source row and column plus linear source and destination addresses
// of a planar layout, in asymmetric or half-pixel mode, floor then clamp to
// [0, in-1]. Throughput is one item per clock while the output is not stalled.
// The datapath holds a 12-stage restoring divider that resolves one quotient
// bit per stage, plus multiply/add stages on either side. Each stage holds its
// own valid bit and advances whenever it or some stage below it has room, so
// the input stays ready while a finished result waits, as long as any stage is
// empty. Write configuration only while the pipeline is empty.
module nearest_resize_source_index (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // plane [11:0], out_row [23:12], out_col [35:24], zero [39:36]
    input  logic [nrsi_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // src_row [11:0], src_col [23:12], src_addr [59:24], dst_addr [95:60]
    output logic [nrsi_pkg::M_DATA_W-1:0]   o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [nrsi_pkg::CIDX_W-1:0]     i_cfg_idx,
    input  logic [nrsi_pkg::DIM_W-1:0]      i_cfg_data
);

    localparam int NS = nrsi_pkg::NUM_STG;

    nrsi_pkg::t_cfg cfg;

    logic [NS-1:0]  r_v;
    logic [NS-1:0]  en;
    nrsi_pkg::t_stg r_stg [NS];
    nrsi_pkg::t_stg n_stg [NS];

    logic [nrsi_pkg::IDX_W-1:0]  in_plane;
    logic [nrsi_pkg::IDX_W-1:0]  in_row;
    logic [nrsi_pkg::IDX_W-1:0]  in_col;
    logic [nrsi_pkg::DIV_W-1:0]  d_row;
    logic [nrsi_pkg::DIV_W-1:0]  d_col;

    nrsi_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign in_plane = i_s_tdata[11:0];
    assign in_row   = i_s_tdata[23:12];
    assign in_col   = i_s_tdata[35:24];
    assign d_row    = nrsi_pkg::div_of(cfg.out_h, cfg.mode);
    assign d_col    = nrsi_pkg::div_of(cfg.out_w, cfg.mode);

    // a stage advances when empty or when the stage below advances
    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    always_comb begin
        n_stg[0]      = r_stg[0];
        n_stg[0].orow = in_row;
        n_stg[0].ocol = in_col;
        n_stg[0].nr   = nrsi_pkg::scale_num(in_row, cfg.in_h, cfg.mode);
        n_stg[0].nc   = nrsi_pkg::scale_num(in_col, cfg.in_w, cfg.mode);
        n_stg[0].src  = nrsi_pkg::ADDR_W'(in_plane) * nrsi_pkg::ADDR_W'(cfg.in_h);
        n_stg[0].dst  = nrsi_pkg::ADDR_W'(in_plane) * nrsi_pkg::ADDR_W'(cfg.out_h);
        for (int k = 1; k < NS; k++) begin
            n_stg[k] = r_stg[k-1];
            if (k == nrsi_pkg::ST_INIT) begin
                n_stg[k].lr  = nrsi_pkg::lane_init(r_stg[k-1].nr, cfg.out_h, cfg.mode);
                n_stg[k].lc  = nrsi_pkg::lane_init(r_stg[k-1].nc, cfg.out_w, cfg.mode);
                n_stg[k].dst = r_stg[k-1].dst + nrsi_pkg::ADDR_W'(r_stg[k-1].orow);
            end else if (k >= nrsi_pkg::ST_DIV0 && k < nrsi_pkg::ST_PICK) begin
                n_stg[k].lr = nrsi_pkg::div_step(r_stg[k-1].lr, d_row);
                n_stg[k].lc = nrsi_pkg::div_step(r_stg[k-1].lc, d_col);
                // destination address rides along the divider stages
                if (k == nrsi_pkg::ST_DIV0) begin
                    n_stg[k].dst = nrsi_pkg::ADDR_W'(r_stg[k-1].dst[24:0])
                                 * nrsi_pkg::ADDR_W'(cfg.out_w);
                end else if (k == nrsi_pkg::ST_DIV0 + 1) begin
                    n_stg[k].dst = r_stg[k-1].dst + nrsi_pkg::ADDR_W'(r_stg[k-1].ocol);
                end
            end else if (k == nrsi_pkg::ST_PICK) begin
                n_stg[k].srow = nrsi_pkg::pick_idx(r_stg[k-1].lr, cfg.in_h);
                n_stg[k].scol = nrsi_pkg::pick_idx(r_stg[k-1].lc, cfg.in_w);
                n_stg[k].src  = r_stg[k-1].src
                              + nrsi_pkg::ADDR_W'(nrsi_pkg::pick_idx(r_stg[k-1].lr,
                                                                       cfg.in_h));
            end else if (k == nrsi_pkg::ST_SCALE) begin
                n_stg[k].src = nrsi_pkg::ADDR_W'(r_stg[k-1].src[24:0])
                             * nrsi_pkg::ADDR_W'(cfg.in_w);
            end else if (k == nrsi_pkg::ST_OUT) begin
                n_stg[k].src = r_stg[k-1].src + nrsi_pkg::ADDR_W'(r_stg[k-1].scol);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_m_tvalid = r_v[NS-1];
    assign o_m_tdata  = {r_stg[NS-1].dst, r_stg[NS-1].src,
                         r_stg[NS-1].scol, r_stg[NS-1].srow};

    // an empty output stage lets the input side take a transfer
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NS-1] |-> o_s_tready)
        else $error("input stalled with an empty output stage");

    // an item entering an empty pipe reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (r_v == '0)) |-> ##NS o_m_tvalid)
        else $error("item lost in an empty pipeline");

    // output valid only rises from a valid item in the stage above
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_v[NS-2]))
        else $error("output valid without a preceding item");

endmodule
